// File: hdl/signed_golomb_encoder_defines.svh
// Assertion macros shared by the encoder's checker.
`ifndef SIGNED_GOLOMB_ENCODER_DEFINES_SVH
`define SIGNED_GOLOMB_ENCODER_DEFINES_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define SGE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define SGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sge_pkg.sv
// Shared types, constants and helpers of the signed Golomb encoder.
package sge_pkg;

  // Width of the divisor register and of the remainder.
  localparam int DIV_W  = 16;
  // Width of the truncated-binary field length (0 to 16).
  localparam int RLEN_W = 5;
  // Width of floor(log2 m) for a 16-bit divisor.
  localparam int LOG_W  = 4;

  // Everything the bit emitter needs besides the quotient.
  typedef struct packed {
    logic              too_long;
    logic              neg;
    logic              has_sign;
    logic [RLEN_W-1:0] rlen;
    logic [DIV_W-1:0]  rv;        // remainder field, MSB-aligned at bit DIV_W-1
  } sge_tail_t;

  // Position of the highest set bit; zero for an input of zero or one.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [DIV_W-1:0] v);
    logic [LOG_W-1:0] b;
    b = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (v[i]) begin
        b = LOG_W'(i);
      end
    end
    return b;
  endfunction

endpackage

// File: hdl/sge_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module sge_divider
  import sge_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_W-1:0]      divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIV_W-1:0]      remainder
);

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic [DIV_W-1:0]      d_r, d_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           fits;

  // Bring down the next dividend bit and try one subtraction.
  assign shifted = {rem_r, quo_r[VALUE_BITS-1]};
  assign fits    = shifted >= {1'b0, d_r};
  assign diff    = shifted - {1'b0, d_r};

  // Step sequencing; the dividend shifts out as the quotient shifts in.
  always_comb begin
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt    = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = STEP_W'(VALUE_BITS);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_nxt  = {quo_r[VALUE_BITS-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: hdl/sge_serializer.sv
// Bit emitter that packs the code into chunks and holds the output register.
module sge_serializer
  import sge_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  parameter int CHUNK_BITS = 32,
  localparam int CNT_W = $clog2(CHUNK_BITS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] q,
  input  sge_tail_t             tail,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHUNK_BITS-1:0] out_code,
  output logic [CNT_W-1:0]      out_cnt,
  output logic                  out_last,
  output logic                  out_flag
);

  localparam int CMP_W = ((VALUE_BITS > CNT_W) ? VALUE_BITS : CNT_W) + 1;

  typedef enum logic [2:0] {
    P_IDLE,
    P_ONES,
    P_ZERO,
    P_REM,
    P_SIGN,
    P_FLAG
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] q_rem_r, q_rem_nxt;
  logic [RLEN_W-1:0]     rcnt_r, rcnt_nxt;
  logic [DIV_W-1:0]      rv_r, rv_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sign_r, sign_nxt;
  logic [CHUNK_BITS-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  oval_r, oval_nxt;
  logic [CHUNK_BITS-1:0] ocode_r, ocode_nxt;
  logic [CNT_W-1:0]      ocnt_r, ocnt_nxt;
  logic                  olast_r, olast_nxt;
  logic                  oflag_r, oflag_nxt;

  logic                  emit;
  logic                  bit_v;
  logic                  bulk;
  logic                  is_final;
  logic                  flush;
  logic                  out_free;
  logic                  adv;
  logic [CHUNK_BITS-1:0] chunk_shift;
  logic [CNT_W-1:0]      cnt_inc;
  logic [VALUE_BITS-1:0] q_dec;

  // Which bit goes out this cycle, and whether it ends a chunk or the code.
  always_comb begin
    emit     = 1'b0;
    bit_v    = 1'b0;
    bulk     = 1'b0;
    is_final = 1'b0;
    case (phase_r)
      P_ONES: begin
        emit  = 1'b1;
        bit_v = 1'b1;
        // A whole chunk of ones goes out at once when the chunk is empty and at least a chunk of ones remains.
        bulk  = (cnt_r == '0) && (CMP_W'(q_rem_r) >= CMP_W'(CHUNK_BITS));
      end
      P_ZERO: begin
        emit     = 1'b1;
        bit_v    = 1'b0;
        is_final = (rcnt_r == '0) && !sign_r;
      end
      P_REM: begin
        emit     = 1'b1;
        bit_v    = rv_r[DIV_W-1];
        is_final = (rcnt_r == RLEN_W'(1)) && !sign_r;
      end
      P_SIGN: begin
        emit     = 1'b1;
        bit_v    = neg_r;
        is_final = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign chunk_shift = {chunk_r[CHUNK_BITS-2:0], bit_v};
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign flush       = emit && (bulk || (cnt_inc == CNT_W'(CHUNK_BITS)) || is_final);
  assign out_free    = !oval_r || out_ready;
  assign adv         = emit && (!flush || out_free);
  assign q_dec       = q_rem_r - (bulk ? VALUE_BITS'(CHUNK_BITS) : VALUE_BITS'(1));

  // Phase sequencing, chunk assembly and the output register.
  always_comb begin
    phase_nxt = phase_r;
    q_rem_nxt = q_rem_r;
    rcnt_nxt  = rcnt_r;
    rv_nxt    = rv_r;
    neg_nxt   = neg_r;
    sign_nxt  = sign_r;
    chunk_nxt = chunk_r;
    cnt_nxt   = cnt_r;
    oval_nxt  = oval_r && !out_ready;
    ocode_nxt = ocode_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    oflag_nxt = oflag_r;

    if (start) begin
      if (tail.too_long) begin
        phase_nxt = P_FLAG;
      end else if (q != '0) begin
        phase_nxt = P_ONES;
      end else begin
        phase_nxt = P_ZERO;
      end
      q_rem_nxt = q;
      rcnt_nxt  = tail.rlen;
      rv_nxt    = tail.rv;
      neg_nxt   = tail.neg;
      sign_nxt  = tail.has_sign;
      chunk_nxt = '0;
      cnt_nxt   = '0;
    end else if (phase_r == P_FLAG) begin
      // A code that is too long gives one empty, flagged item.
      if (out_free) begin
        oval_nxt  = 1'b1;
        ocode_nxt = '0;
        ocnt_nxt  = '0;
        olast_nxt = 1'b1;
        oflag_nxt = 1'b1;
        phase_nxt = P_IDLE;
      end
    end else if (adv) begin
      case (phase_r)
        P_ONES: begin
          q_rem_nxt = q_dec;
          if (q_dec == '0) begin
            phase_nxt = P_ZERO;
          end
        end
        P_ZERO: begin
          if (rcnt_r != '0) begin
            phase_nxt = P_REM;
          end else if (sign_r) begin
            phase_nxt = P_SIGN;
          end else begin
            phase_nxt = P_IDLE;
          end
        end
        P_REM: begin
          rv_nxt   = {rv_r[DIV_W-2:0], 1'b0};
          rcnt_nxt = rcnt_r - RLEN_W'(1);
          if (rcnt_r == RLEN_W'(1)) begin
            phase_nxt = sign_r ? P_SIGN : P_IDLE;
          end
        end
        default: begin
          phase_nxt = P_IDLE;
        end
      endcase

      if (flush) begin
        chunk_nxt = '0;
        cnt_nxt   = '0;
        oval_nxt  = 1'b1;
        ocode_nxt = bulk ? '1 : chunk_shift;
        ocnt_nxt  = bulk ? CNT_W'(CHUNK_BITS) : cnt_inc;
        olast_nxt = is_final;
        oflag_nxt = 1'b0;
      end else begin
        chunk_nxt = chunk_shift;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      oval_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      oval_r  <= oval_nxt;
      cnt_r   <= cnt_nxt;
    end
    q_rem_r <= q_rem_nxt;
    rcnt_r  <= rcnt_nxt;
    rv_r    <= rv_nxt;
    neg_r   <= neg_nxt;
    sign_r  <= sign_nxt;
    chunk_r <= chunk_nxt;
    ocode_r <= ocode_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    oflag_r <= oflag_nxt;
  end

  assign busy      = phase_r != P_IDLE;
  assign out_valid = oval_r;
  assign out_code  = ocode_r;
  assign out_cnt   = ocnt_r;
  assign out_last  = olast_r;
  assign out_flag  = oflag_r;

endmodule

// File: hdl/signed_golomb_encoder.sv
// Each item passes through the bit-serial divider and setup, then its code leaves one bit
// per cycle, except that whole chunks of unary ones leave one per cycle, both only while
// the output does not stall; the next item is taken only after the last chunk is built.
// Synchronous active-low reset sets the divisor to one and empties the output.
module signed_golomb_encoder
  import sge_pkg::*;
#(
  parameter int MAX_CODE_BITS = 1024,
  parameter int CHUNK_BITS    = 32,
  parameter int VALUE_BITS    = 16,
  localparam int CNT_W        = $clog2(CHUNK_BITS + 1),
  localparam int IN_W         = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W        = ((CHUNK_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wen,
  input  logic [DIV_W-1:0] cfg_wdata,   // divisor
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,    // sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,   // code_bits, bit_count
  output logic             out_tlast,
  output logic             out_tuser    // too_long
);

  localparam int TOT_W = (VALUE_BITS + 2 > 18) ? VALUE_BITS + 2 : 18;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DIV,
    T_SPLIT,
    T_LAUNCH,
    T_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [DIV_W-1:0]    divisor_r, divisor_nxt;
  logic [DIV_W:0]      k_r, k_nxt;
  logic [LOG_W-1:0]    blog_r, blog_nxt;
  logic                neg_r, neg_nxt;
  logic                nz_r, nz_nxt;
  logic [RLEN_W-1:0]   rlen_r, rlen_nxt;
  logic [DIV_W-1:0]    rval_r, rval_nxt;

  logic                  accept;
  logic [VALUE_BITS-1:0] sample;
  logic [VALUE_BITS-1:0] mag;
  logic [DIV_W-1:0]      m_eff;
  logic [LOG_W-1:0]      blog;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_q;
  logic [DIV_W-1:0]      div_r;
  logic                  rem_ge;
  logic [DIV_W:0]        rem_sum;
  logic [TOT_W-1:0]      total;
  logic                  ser_start;
  logic                  ser_busy;
  sge_tail_t             tail;
  logic [CHUNK_BITS-1:0] code_bits;
  logic [CNT_W-1:0]      bit_count;

  assign in_tready = state_r == T_IDLE;
  assign accept    = in_tvalid && in_tready;

  // Sign and magnitude; the most negative value keeps its own bit pattern.
  assign sample = in_tdata[VALUE_BITS-1:0];
  assign mag    = sample[VALUE_BITS-1] ? (~sample + VALUE_BITS'(1)) : sample;

  // A divisor of zero acts as one.
  assign m_eff = (divisor_r == '0) ? DIV_W'(1) : divisor_r;
  assign blog  = floor_log2(m_eff);

  // Truncated-binary split of the remainder.
  assign rem_ge  = {1'b0, div_r} >= k_r;
  assign rem_sum = {1'b0, div_r} + k_r;

  // Code length: unary run, its stop bit, remainder field and sign bit.
  assign total = TOT_W'(div_q) + TOT_W'(rlen_r) + TOT_W'(nz_r) + TOT_W'(1);

  assign ser_start     = state_r == T_LAUNCH;
  assign tail.too_long = total > TOT_W'(MAX_CODE_BITS);
  assign tail.neg      = neg_r;
  assign tail.has_sign = nz_r;
  assign tail.rlen     = rlen_r;
  assign tail.rv       = rval_r << (RLEN_W'(DIV_W) - rlen_r);

  // Control sequence and per-item registers.
  always_comb begin
    state_nxt   = state_r;
    divisor_nxt = divisor_r;
    k_nxt       = k_r;
    blog_nxt    = blog_r;
    neg_nxt     = neg_r;
    nz_nxt      = nz_r;
    rlen_nxt    = rlen_r;
    rval_nxt    = rval_r;
    if (cfg_wen) begin
      divisor_nxt = cfg_wdata;
    end
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          blog_nxt  = blog;
          k_nxt     = ((DIV_W + 1)'(1) << (RLEN_W'(blog) + RLEN_W'(1))) - {1'b0, m_eff};
          neg_nxt   = sample[VALUE_BITS-1];
          nz_nxt    = sample != '0;
          state_nxt = T_DIV;
        end
      end
      T_DIV: begin
        if (div_done) begin
          state_nxt = T_SPLIT;
        end
      end
      T_SPLIT: begin
        rlen_nxt  = rem_ge ? (RLEN_W'(blog_r) + RLEN_W'(1)) : RLEN_W'(blog_r);
        rval_nxt  = rem_ge ? rem_sum[DIV_W-1:0] : div_r;
        state_nxt = T_LAUNCH;
      end
      T_LAUNCH: begin
        state_nxt = T_EMIT;
      end
      T_EMIT: begin
        if (!ser_busy) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= T_IDLE;
      divisor_r <= DIV_W'(1);
    end else begin
      state_r   <= state_nxt;
      divisor_r <= divisor_nxt;
    end
    k_r    <= k_nxt;
    blog_r <= blog_nxt;
    neg_r  <= neg_nxt;
    nz_r   <= nz_nxt;
    rlen_r <= rlen_nxt;
    rval_r <= rval_nxt;
  end

  sge_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .dividend  (mag),
    .divisor   (m_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  sge_serializer #(
    .VALUE_BITS(VALUE_BITS),
    .CHUNK_BITS(CHUNK_BITS)
  ) u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ser_start),
    .q         (div_q),
    .tail      (tail),
    .busy      (ser_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (code_bits),
    .out_cnt   (bit_count),
    .out_last  (out_tlast),
    .out_flag  (out_tuser)
  );

  assign out_tdata = OUT_W'({bit_count, code_bits});

endmodule

// File: hdl/sge_checker.sv
// Port-level checks on the encoder's result stream, bound to the top level.
`include "signed_golomb_encoder_defines.svh"

module sge_checker #(
  parameter int CHUNK_BITS = 32,
  localparam int CNT_W     = $clog2(CHUNK_BITS + 1),
  localparam int OUT_W     = ((CHUNK_BITS + CNT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser
);

  logic [CHUNK_BITS-1:0] code;
  logic [CNT_W-1:0]      cnt;

  assign code = out_tdata[CHUNK_BITS-1:0];
  assign cnt  = out_tdata[CHUNK_BITS +: CNT_W];

  // A flagged item stands alone: empty and final.
  `SGE_ASSERT_IMPL(a_flag_alone, out_tvalid && out_tuser, out_tlast && (cnt == '0) && (code == '0), "flagged item is not an empty final item")

  // Every item before the last of a code is a full, unflagged chunk.
  `SGE_ASSERT_IMPL(a_full_chunk, out_tvalid && !out_tlast, (cnt == CNT_W'(CHUNK_BITS)) && !out_tuser, "non-final item is not a full chunk")

  // An unflagged item carries between one and a chunk of bits.
  `SGE_ASSERT_IMPL(a_count_range, out_tvalid && !out_tuser, (cnt != '0) && (cnt <= CNT_W'(CHUNK_BITS)), "bit count out of range")

  // A stalled item is held unchanged.
  `SGE_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled item changed")

endmodule

bind signed_golomb_encoder sge_checker #(
  .CHUNK_BITS(CHUNK_BITS)
) u_sge_checker (.*);

// File: bench/tb_top.sv
// Self-checking testbench for the signed Golomb encoder with random stream handshakes.
module tb_top;
  import sge_pkg::*;

  localparam int MAX_CODE_BITS = 1024;
  localparam int CHUNK_BITS    = 32;
  localparam int IDLE_LIMIT    = 5000;

  // One output chunk as the checker sees it.
  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  bit_count;
    logic        last;
    logic        too_long;
  } golomb_chunk_t;

  // Predicts the chunk stream of each accepted sample and checks what the block sends.
  class golomb_scoreboard;
    golomb_chunk_t    expected_chunks[$];
    logic [DIV_W-1:0] divisor;
    int               errors;
    int               samples_seen;
    int               chunks_seen;
    int               flagged_seen;

    function new();
      divisor      = 16'd1;
      errors       = 0;
      samples_seen = 0;
      chunks_seen  = 0;
      flagged_seen = 0;
    endfunction

    function void set_divisor(input logic [DIV_W-1:0] value);
      divisor = value;
    endfunction

    // Encodes one sample and queues every chunk it should produce.
    function void note_sample(input logic [15:0] sample);
      int unsigned   mag;
      int unsigned   m;
      int unsigned   quot;
      int unsigned   rem;
      int unsigned   log2m;
      int unsigned   tmp;
      int unsigned   offset;
      int unsigned   rlen;
      int unsigned   rval;
      int unsigned   total;
      int unsigned   fill;
      logic          neg;
      logic          code_bit;
      logic [31:0]   acc;
      golomb_chunk_t chunk;
      neg = sample[15];
      mag = neg ? (32'd65536 - {16'd0, sample}) : {16'd0, sample};
      m = (divisor == '0) ? 1 : divisor;
      quot = mag / m;
      rem  = mag % m;
      log2m = 0;
      tmp = m;
      while (tmp > 1) begin
        tmp = tmp >> 1;
        log2m++;
      end
      // Truncated binary: short field below the offset, long field at or above it.
      offset = (1 << (log2m + 1)) - m;
      rlen = log2m;
      rval = rem;
      if (rem >= offset) begin
        rlen = log2m + 1;
        rval = rem + offset;
      end
      total = quot + 1 + rlen + ((mag != 0) ? 1 : 0);
      samples_seen++;
      if (total > MAX_CODE_BITS) begin
        chunk = '{code_bits: '0, bit_count: '0, last: 1'b1, too_long: 1'b1};
        expected_chunks.push_back(chunk);
        return;
      end
      acc = '0;
      fill = 0;
      for (int unsigned p = 0; p < total; p++) begin
        if (p < quot) begin
          code_bit = 1'b1;
        end else if (p == quot) begin
          code_bit = 1'b0;
        end else if (p < quot + 1 + rlen) begin
          code_bit = rval[rlen - 1 - (p - quot - 1)];
        end else begin
          code_bit = neg;
        end
        acc = {acc[30:0], code_bit};
        fill++;
        if (fill == CHUNK_BITS || p + 1 == total) begin
          chunk = '{code_bits: acc, bit_count: 6'(fill), last: (p + 1 == total),
                    too_long: 1'b0};
          expected_chunks.push_back(chunk);
          acc = '0;
          fill = 0;
        end
      end
    endfunction

    // Compares one accepted chunk with the oldest expectation.
    function void check_chunk(input golomb_chunk_t got);
      golomb_chunk_t want;
      chunks_seen++;
      if (got.too_long) begin
        flagged_seen++;
      end
      if (expected_chunks.size() == 0) begin
        errors++;
        $display("%0t: unexpected chunk, expected none, got %h", $time, got);
        return;
      end
      want = expected_chunks.pop_front();
      if (got.code_bits !== want.code_bits) begin
        errors++;
        $display("%0t: code_bits expected %h got %h", $time, want.code_bits, got.code_bits);
      end
      if (got.bit_count !== want.bit_count) begin
        errors++;
        $display("%0t: bit_count expected %0d got %0d", $time, want.bit_count, got.bit_count);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %b got %b", $time, want.last, got.last);
      end
      if (got.too_long !== want.too_long) begin
        errors++;
        $display("%0t: too_long expected %b got %b", $time, want.too_long, got.too_long);
      end
    endfunction

    function int pending();
      return expected_chunks.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wen;
  logic [DIV_W-1:0] cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [39:0]      out_tdata;
  logic             out_tlast;
  logic             out_tuser;

  golomb_scoreboard chunk_board;
  bit               in_burst;
  bit               out_burst;
  int               idle_cycles;
  int               settings_used;

  signed_golomb_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = ~clk;
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("signed_golomb_encoder verification failed");
        $finish;
      end
    end
  end

  // Offers one sample, after a random gap unless in_burst is set, and waits until the block takes it.
  task automatic send_sample(input logic [15:0] sample);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do begin
      @(posedge clk);
    end while (!(in_tvalid && in_tready));
    chunk_board.note_sample(sample);
  endtask

  // Lets the block drain, then writes a new divisor while it is idle.
  task automatic write_divisor(input logic [DIV_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (chunk_board.pending() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    chunk_board.set_divisor(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  // Random sample, mostly sized so that the code stays short for this divisor.
  function automatic logic [15:0] pick_sample(input int unsigned divisor);
    int unsigned m;
    int unsigned mode;
    int unsigned mag;
    m = (divisor == 0) ? 1 : divisor;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      return 16'($urandom_range(0, 65535));
    end
    if (mode == 9) begin
      // Near the length limit of the code.
      mag = m * $urandom_range(1015, 1030) + $urandom_range(0, m - 1);
    end else begin
      mag = $urandom_range(0, (m * 40 > 32768) ? 32768 : m * 40);
    end
    if (mag > 32768) begin
      mag = 32768;
    end
    if ($urandom_range(0, 1) == 1) begin
      return 16'(32'd65536 - mag);
    end
    return 16'((mag > 32767) ? 32767 : mag);
  endfunction

  // Result side: random stalls per chunk unless out_burst is set, checked on every accepted chunk.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!(out_tvalid && out_tready));
      chunk_board.check_chunk('{code_bits: out_tdata[31:0], bit_count: out_tdata[37:32],
                                last: out_tlast, too_long: out_tuser});
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned phase_div [7];
    chunk_board   = new();
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    idle_cycles   = 0;
    settings_used = 0;
    rst_n     = 1'b0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset divisor of one: zero, unit values, the longest legal code, one past it and both extremes.
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'hFFFF);
    send_sample(16'd1022);
    send_sample(16'd1023);
    send_sample(16'h8000);
    send_sample(16'd32767);

    // A divisor of zero behaves as one.
    write_divisor(16'd0);
    send_sample(16'd5);
    send_sample(16'hFFFB);

    // Largest divisor: long remainder fields, including the most negative sample.
    write_divisor(16'hFFFF);
    send_sample(16'd0);
    send_sample(16'd32767);
    send_sample(16'h8000);
    send_sample(16'hFFFF);

    // Divisor five covers both the short and the long truncated-binary field.
    write_divisor(16'd5);
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'd3);
    send_sample(16'd4);
    send_sample(16'hFFFC);
    send_sample(16'd7);

    // A power of two always takes the short field.
    write_divisor(16'd8);
    send_sample(16'd3);
    send_sample(16'hFFF4);

    // Random phases over several divisors, some with back-to-back traffic.
    phase_div = '{3, 1, 37, 1000, 65535, 256, $urandom_range(2, 65534)};
    foreach (phase_div[i]) begin
      write_divisor(16'(phase_div[i]));
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      repeat (30) begin
        send_sample(pick_sample(phase_div[i]));
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (chunk_board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (chunk_board.pending() != 0) begin
      chunk_board.errors++;
      $display("%0t: %0d chunks never arrived, first expected %h", $time,
               chunk_board.pending(), chunk_board.expected_chunks[0]);
    end
    $display("Encoded %0d samples under %0d divisor writes into %0d chunks.",
             chunk_board.samples_seen, settings_used, chunk_board.chunks_seen);
    $display("Of those, %0d codes were flagged as too long.", chunk_board.flagged_seen);
    if (chunk_board.errors == 0) begin
      $display("signed_golomb_encoder verification clean");
    end else begin
      $display("signed_golomb_encoder verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/sge_pkg.sv
hdl/sge_divider.sv
hdl/sge_serializer.sv
hdl/signed_golomb_encoder.sv
hdl/sge_checker.sv
bench/tb_top.sv
